// ===== design/assert_macros.svh =====
// Assertion macros shared by the species posterior RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, ck, rst_n, cond, msg) \
	`ASSERT_PROP(lbl, ck, rst_n, !(cond), msg)

`endif

// ===== design/bsp_pkg.sv =====
// Shared types, constants and helpers of the species posterior block.
`default_nettype none

package bsp_pkg;

	// Fixed-point format of densities, priors and posteriors.
	localparam int FRAC_BITS = 16;
	localparam int WEIGHT_W  = 2 * FRAC_BITS;
	localparam int SPECIES_W = 4;

	// Default species counts.
	localparam int SPECIES_ALL_DEF     = 14;
	localparam int SPECIES_CHARGED_DEF = 9;

	// Species reported when every weight is zero.
	localparam logic [SPECIES_W-1:0] PION_ID = 4'd2;

	// Depth of the command queue between front and back.
	localparam int CMDQ_DEPTH = 4;

	// Operation codes of an input request.
	typedef enum logic [1:0] {
		OP_SET_DENSITY = 2'd0,
		OP_COMBINE     = 2'd1,
		OP_SET_PRIOR   = 2'd2,
		OP_QUERY       = 2'd3
	} op_t;

	// Input request as it arrives on the push side.
	typedef struct packed {
		logic [1:0]           operation;
		logic [SPECIES_W-1:0] species;
		logic [FRAC_BITS-1:0] value;
	} item_t;

	// One result as it leaves on the pop side.
	typedef struct packed {
		logic [SPECIES_W-1:0] species_out;
		logic [FRAC_BITS-1:0] posterior;
		logic [SPECIES_W-1:0] most_probable;
		logic                 invalid;
		logic                 last_result;
	} result_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		op_t                  op;
		logic [SPECIES_W-1:0] species;
		logic [FRAC_BITS-1:0] value;
	} cmd_t;

	// Width of the weighted sum over a given number of species.
	function automatic int sum_width(input int n);
		return WEIGHT_W + $clog2(n);
	endfunction

endpackage

`default_nettype wire

// ===== design/bsp_front.sv =====
// Front end: classifies input requests and queues them for the back end.
`default_nettype none

`include "assert_macros.svh"

module bsp_front #(
	parameter int SPECIES_ALL     = bsp_pkg::SPECIES_ALL_DEF,
	parameter int SPECIES_CHARGED = bsp_pkg::SPECIES_CHARGED_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             charged_only,
	input  wire             push,
	input  bsp_pkg::item_t  item,
	output logic            full,
	output logic            cmd_vld,
	output bsp_pkg::cmd_t   cmd,
	input  wire             cmd_pop
);

	localparam int DEPTH = bsp_pkg::CMDQ_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	bsp_pkg::cmd_t   q_mem [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CNTW-1:0] cnt_q;

	bsp_pkg::op_t    op;
	logic            in_range;
	logic            neutral;
	logic            keep;
	logic            enq;
	bsp_pkg::cmd_t   cls;

	// Classify: drop table writes to missing species, zero neutral densities in charged-only mode.
	always_comb begin
		op       = bsp_pkg::op_t'(item.operation);
		in_range = ({1'b0, item.species} < 5'(SPECIES_ALL));
		neutral  = ({1'b0, item.species} >= 5'(SPECIES_CHARGED));
		keep     = (op == bsp_pkg::OP_QUERY) || in_range;
		cls.op      = op;
		cls.species = item.species;
		cls.value   = item.value;
		if ((op == bsp_pkg::OP_SET_DENSITY) && charged_only && neutral) begin
			cls.value = '0;
		end
	end

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign enq     = push && !full && keep;
	assign cmd_vld = (cnt_q != '0);
	assign cmd     = q_mem[rd_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + PW'(1);
			end
			if (cmd_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CNTW'(enq) - CNTW'(cmd_pop);
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_q] <= cls;
		end
	end

	`ASSERT_NEVER(a_pop_empty, clk, arst_n, cmd_pop && (cnt_q == '0), "command popped while queue empty")

endmodule

`default_nettype wire

// ===== design/bsp_div.sv =====
// Iterative fraction divider: floor(num * 2^FRAC_BITS / den), one bit per cycle; all ones when num >= den.
`default_nettype none

`include "assert_macros.svh"

module bsp_div #(
	parameter int SUM_W = bsp_pkg::sum_width(bsp_pkg::SPECIES_ALL_DEF)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire [bsp_pkg::WEIGHT_W-1:0]    num,
	input  wire [SUM_W-1:0]                den,
	output logic                           done,
	output logic [bsp_pkg::FRAC_BITS-1:0]  quo
);

	localparam int F  = bsp_pkg::FRAC_BITS;
	localparam int CW = $clog2(F + 1);

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] den_q;
	logic [F-1:0]     quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SUM_W:0]   shifted;
	logic             fits;

	// One restoring step: shift the remainder and try to take the divisor.
	always_comb begin
		shifted = {rem_q, 1'b0};
		fits    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (SUM_W'(num) >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(F);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, divisor and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_W'(num);
			den_q <= den;
			quo_q <= (SUM_W'(num) >= den) ? '1 : '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= SUM_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[SUM_W-1:0];
			end
			quo_q <= {quo_q[F-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`ASSERT_NEVER(a_start_busy, clk, arst_n, start && busy_q, "divider started while busy")

endmodule

`default_nettype wire

// ===== design/bsp_back.sv =====
// Back end: species tables, weighted sum walk and per-species result sequencer.
`default_nettype none

`include "assert_macros.svh"

module bsp_back #(
	parameter int SPECIES_ALL     = bsp_pkg::SPECIES_ALL_DEF,
	parameter int SPECIES_CHARGED = bsp_pkg::SPECIES_CHARGED_DEF,
	parameter int SUM_W           = bsp_pkg::sum_width(bsp_pkg::SPECIES_ALL_DEF)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            charged_only,
	input  wire                            cmd_vld,
	input  bsp_pkg::cmd_t                  cmd,
	output logic                           cmd_pop,
	output logic                           div_start,
	output logic [bsp_pkg::WEIGHT_W-1:0]   div_num,
	output logic [SUM_W-1:0]               div_den,
	input  wire                            div_done,
	input  wire [bsp_pkg::FRAC_BITS-1:0]   div_quo,
	output logic                           empty,
	input  wire                            pop,
	output bsp_pkg::result_t               result
);

	localparam int F     = bsp_pkg::FRAC_BITS;
	localparam int WW    = bsp_pkg::WEIGHT_W;
	localparam int IW    = (SPECIES_ALL > 1) ? $clog2(SPECIES_ALL) : 1;
	localparam int CW    = $clog2(SPECIES_ALL + 1);
	localparam int N_CHG = (SPECIES_CHARGED > SPECIES_ALL) ? SPECIES_ALL : SPECIES_CHARGED;
	localparam logic [F-1:0] DENS_INIT = F'((2 ** F) / SPECIES_ALL);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMB_WR,
		ST_SUM,
		ST_SUM_DRAIN,
		ST_EMIT_MUL,
		ST_EMIT_START,
		ST_EMIT_WAIT,
		ST_EMIT_OUT
	} state_t;

	state_t                       state_q;
	logic [F-1:0]                 dens_q  [SPECIES_ALL];
	logic [F-1:0]                 prior_q [SPECIES_ALL];
	logic [IW-1:0]                sp_q;
	logic [CW-1:0]                idx_q;
	logic [SUM_W-1:0]             sum_q;
	logic [WW-1:0]                best_q;
	logic [bsp_pkg::SPECIES_W-1:0] best_id_q;
	logic                         acc_s1;
	logic [WW-1:0]                prod_s1;
	logic [CW-1:0]                idx_s1;
	logic                         res_vld_q;
	bsp_pkg::result_t             res_q;

	logic [IW-1:0]                rd_idx;
	logic [F-1:0]                 mul_a;
	logic [F-1:0]                 mul_b;
	logic [CW-1:0]                n_use;
	logic                         last;
	logic                         invalid;
	logic                         res_load;
	logic [IW-1:0]                cmd_sp;

	// Table read port and multiplier operands.
	always_comb begin
		cmd_sp   = cmd.species[IW-1:0];
		rd_idx   = (state_q == ST_IDLE) ? cmd_sp : idx_q[IW-1:0];
		mul_a    = dens_q[rd_idx];
		mul_b    = (state_q == ST_IDLE) ? cmd.value : prior_q[rd_idx];
		n_use    = charged_only ? CW'(N_CHG) : CW'(SPECIES_ALL);
		last     = (idx_q == n_use - CW'(1));
		invalid  = (sum_q == '0);
		res_load = (state_q == ST_EMIT_OUT) && (!res_vld_q || pop);
	end

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_vld;
	assign div_start = (state_q == ST_EMIT_START) && !invalid;
	assign div_num   = prod_s1;
	assign div_den   = sum_q;
	assign empty     = !res_vld_q;
	assign result    = res_q;

	// Multiplier stage: density times prior, or density times new density.
	always_ff @(posedge clk) begin
		prod_s1 <= WW'(mul_a) * WW'(mul_b);
		idx_s1  <= idx_q;
	end

	// Sequencer, tables, running sum and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			for (int i = 0; i < SPECIES_ALL; i++) begin
				dens_q[i]  <= DENS_INIT;
				prior_q[i] <= '0;
			end
			sp_q      <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			best_q    <= '0;
			best_id_q <= bsp_pkg::PION_ID;
			acc_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			acc_s1 <= (state_q == ST_SUM);

			// Accumulate each weight and track the strict-greater maximum.
			if (acc_s1) begin
				sum_q <= sum_q + SUM_W'(prod_s1);
				if (prod_s1 > best_q) begin
					best_q    <= prod_s1;
					best_id_q <= bsp_pkg::SPECIES_W'(idx_s1);
				end
			end

			// Result register handshake: a new load replaces a popped result.
			if (res_load) begin
				res_vld_q           <= 1'b1;
				res_q.species_out   <= bsp_pkg::SPECIES_W'(idx_q);
				res_q.posterior     <= invalid ? '0 : div_quo;
				res_q.most_probable <= best_id_q;
				res_q.invalid       <= invalid;
				res_q.last_result   <= last;
			end else if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_vld) begin
						case (cmd.op)
							bsp_pkg::OP_SET_DENSITY: begin
								dens_q[cmd_sp] <= cmd.value;
							end
							bsp_pkg::OP_COMBINE: begin
								sp_q    <= cmd_sp;
								state_q <= ST_COMB_WR;
							end
							bsp_pkg::OP_SET_PRIOR: begin
								prior_q[cmd_sp] <= cmd.value;
							end
							bsp_pkg::OP_QUERY: begin
								idx_q     <= '0;
								sum_q     <= '0;
								best_q    <= '0;
								best_id_q <= bsp_pkg::PION_ID;
								state_q   <= ST_SUM;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_COMB_WR: begin
					dens_q[sp_q] <= prod_s1[WW-1:F];
					state_q      <= ST_IDLE;
				end
				ST_SUM: begin
					if (last) begin
						state_q <= ST_SUM_DRAIN;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_SUM_DRAIN: begin
					idx_q   <= '0;
					state_q <= ST_EMIT_MUL;
				end
				ST_EMIT_MUL: begin
					state_q <= ST_EMIT_START;
				end
				ST_EMIT_START: begin
					state_q <= invalid ? ST_EMIT_OUT : ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (div_done) begin
						state_q <= ST_EMIT_OUT;
					end
				end
				ST_EMIT_OUT: begin
					if (res_load) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= ST_EMIT_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_res_overwrite, clk, arst_n, res_load && res_vld_q && !pop, "result overwritten before pop")
	`ASSERT_NEVER(a_invalid_zero, clk, arst_n, res_vld_q && res_q.invalid && (res_q.posterior != '0), "invalid result with nonzero posterior")
	`ASSERT_PROP(a_last_idle, clk, arst_n, (res_load && last) |=> (state_q == ST_IDLE), "sequencer did not return to idle after last result")

endmodule

`default_nettype wire

// ===== design/bayesian_species_posterior_top.sv =====
// Top level of the Bayesian species posterior block.
//
//  channel   handshake           payload                   direction
//  item      push / full         bsp_pkg::item_t           in
//  result    pop / empty         bsp_pkg::result_t         out
//  config    cfg_we              cfg_data (charged_only)   in
//
// Set-density and set-prior requests are applied in the back end's idle state; a combine also
// passes through a write-back state. A query walks the n species in use through the one
// multiplier to form the sum, then divides each weight in the divider, one bit per cycle.
// Reset loads every density with 2^FRAC_BITS / SPECIES_ALL and every prior with zero.
// A four-deep command queue keeps taking requests until full while the back end or the result pop stalls.
`default_nettype none

module bayesian_species_posterior_top #(
	parameter int SPECIES_ALL     = bsp_pkg::SPECIES_ALL_DEF,
	parameter int SPECIES_CHARGED = bsp_pkg::SPECIES_CHARGED_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire               cfg_data,
	input  wire               push,
	input  bsp_pkg::item_t    item,
	output logic              full,
	input  wire               pop,
	output logic              empty,
	output bsp_pkg::result_t  result
);

	localparam int SUM_W = bsp_pkg::sum_width(SPECIES_ALL);

	logic                          charged_only_q;
	logic                          cmd_vld;
	bsp_pkg::cmd_t                 cmd;
	logic                          cmd_pop;
	logic                          div_start;
	logic [bsp_pkg::WEIGHT_W-1:0]  div_num;
	logic [SUM_W-1:0]              div_den;
	logic                          div_done;
	logic [bsp_pkg::FRAC_BITS-1:0] div_quo;

	// Charged-only mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charged_only_q <= 1'b0;
		end else if (cfg_we) begin
			charged_only_q <= cfg_data;
		end
	end

	bsp_front #(
		.SPECIES_ALL     (SPECIES_ALL),
		.SPECIES_CHARGED (SPECIES_CHARGED)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.charged_only (charged_only_q),
		.push         (push),
		.item         (item),
		.full         (full),
		.cmd_vld      (cmd_vld),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	bsp_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	bsp_back #(
		.SPECIES_ALL     (SPECIES_ALL),
		.SPECIES_CHARGED (SPECIES_CHARGED),
		.SUM_W           (SUM_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.charged_only (charged_only_q),
		.cmd_vld      (cmd_vld),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.div_start    (div_start),
		.div_num      (div_num),
		.div_den      (div_den),
		.div_done     (div_done),
		.div_quo      (div_quo),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== test/tb_bayesian_species_posterior_top.sv =====
// Self-checking testbench for the Bayesian species posterior block.
module tb_bayesian_species_posterior_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPECIES_N = bsp_pkg::SPECIES_ALL_DEF;
	localparam int CHARGED_N = bsp_pkg::SPECIES_CHARGED_DEF;
	// Settle time that covers the longest query with margin.
	localparam int SETTLE_CYCLES = 400;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_data = 1'b0;
	logic             push = 1'b0;
	bsp_pkg::item_t   item = '0;
	logic             full;
	logic             pop = 1'b0;
	logic             empty;
	bsp_pkg::result_t result;

	// Predictor state: one density and one prior per species, plus the mode.
	logic [bsp_pkg::FRAC_BITS-1:0] density_mem [SPECIES_N];
	logic [bsp_pkg::FRAC_BITS-1:0] prior_mem [SPECIES_N];
	bit                            charged_mode = 1'b0;

	bsp_pkg::item_t   requests_to_send [$];
	bsp_pkg::result_t posteriors_due [$];
	int               mismatch_count = 0;
	int               push_gap = 0;
	int               pop_gap = 0;
	bit               gaps_off = 1'b0;

	bayesian_species_posterior_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (item),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bsp_pkg::item_t make_req(input bsp_pkg::op_t op,
			input logic [bsp_pkg::SPECIES_W-1:0] sp,
			input logic [bsp_pkg::FRAC_BITS-1:0] val);
		bsp_pkg::item_t r;
		r.operation = op;
		r.species = sp;
		r.value = val;
		return r;
	endfunction

	// Random request; most address valid species, a few fall out of range.
	function automatic bsp_pkg::item_t random_request();
		int pick;
		int vsel;
		bsp_pkg::op_t op;
		logic [bsp_pkg::SPECIES_W-1:0] sp;
		logic [bsp_pkg::FRAC_BITS-1:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			op = bsp_pkg::OP_SET_PRIOR;
		end else if (pick < 55) begin
			op = bsp_pkg::OP_SET_DENSITY;
		end else if (pick < 70) begin
			op = bsp_pkg::OP_COMBINE;
		end else begin
			op = bsp_pkg::OP_QUERY;
		end
		if ($urandom_range(0, 9) == 0) begin
			sp = bsp_pkg::SPECIES_W'($urandom_range(SPECIES_N, 15));
		end else begin
			sp = bsp_pkg::SPECIES_W'($urandom_range(0, SPECIES_N - 1));
		end
		vsel = $urandom_range(0, 9);
		if (vsel == 0) begin
			val = '0;
		end else if (vsel == 1) begin
			val = '1;
		end else if (vsel == 2) begin
			val = bsp_pkg::FRAC_BITS'($urandom_range(1, 15));
		end else begin
			val = bsp_pkg::FRAC_BITS'($urandom());
		end
		return make_req(op, sp, val);
	endfunction

	// Apply one accepted request to the tables, or queue the posteriors of a query.
	task automatic process_species_request(input bsp_pkg::item_t req);
		logic [2*bsp_pkg::FRAC_BITS-1:0] weight [SPECIES_N];
		logic [2*bsp_pkg::FRAC_BITS-1:0] prod;
		logic [2*bsp_pkg::FRAC_BITS+3:0] total;
		logic [2*bsp_pkg::FRAC_BITS-1:0] top_weight;
		logic [bsp_pkg::SPECIES_W-1:0]   top_id;
		logic [63:0]                     quo;
		int                              n;
		bsp_pkg::op_t                    op;
		bsp_pkg::result_t                r;
		op = bsp_pkg::op_t'(req.operation);
		if (op != bsp_pkg::OP_QUERY) begin
			if (req.species < SPECIES_N) begin
				case (op)
					bsp_pkg::OP_SET_DENSITY: begin
						if (charged_mode && req.species >= CHARGED_N)
							density_mem[req.species] = '0;
						else
							density_mem[req.species] = req.value;
					end
					bsp_pkg::OP_COMBINE: begin
						prod = density_mem[req.species] * req.value;
						density_mem[req.species] =
							prod[2*bsp_pkg::FRAC_BITS-1:bsp_pkg::FRAC_BITS];
					end
					default: begin
						prior_mem[req.species] = req.value;
					end
				endcase
			end
			return;
		end

		n = charged_mode ? CHARGED_N : SPECIES_N;
		if (n > SPECIES_N)
			n = SPECIES_N;

		// Weights, their sum and the first strictly largest nonzero weight.
		total = '0;
		top_weight = '0;
		top_id = bsp_pkg::PION_ID;
		for (int i = 0; i < n; i++) begin
			weight[i] = density_mem[i] * prior_mem[i];
			total += weight[i];
			if (weight[i] > top_weight) begin
				top_weight = weight[i];
				top_id = bsp_pkg::SPECIES_W'(i);
			end
		end

		// One posterior per species in use, saturated at all ones.
		for (int i = 0; i < n; i++) begin
			r.species_out = bsp_pkg::SPECIES_W'(i);
			r.most_probable = top_id;
			r.invalid = (total == 0);
			r.last_result = (i == n - 1);
			if (total == 0) begin
				r.posterior = '0;
			end else if (weight[i] >= total) begin
				r.posterior = '1;
			end else begin
				quo = {weight[i], {bsp_pkg::FRAC_BITS{1'b0}}} / 64'(total);
				r.posterior = quo[bsp_pkg::FRAC_BITS-1:0];
			end
			posteriors_due.push_back(r);
		end
	endtask

	task automatic check_posterior(input bsp_pkg::result_t got);
		bsp_pkg::result_t want;
		if (posteriors_due.size() == 0) begin
			$error("unexpected result for species %0d", got.species_out);
			mismatch_count++;
			return;
		end
		want = posteriors_due.pop_front();
		if (got.species_out !== want.species_out) begin
			$error("species_out: expected %0d, got %0d", want.species_out, got.species_out);
			mismatch_count++;
		end
		if (got.posterior !== want.posterior) begin
			$error("posterior: expected %0d, got %0d", want.posterior, got.posterior);
			mismatch_count++;
		end
		if (got.most_probable !== want.most_probable) begin
			$error("most_probable: expected %0d, got %0d", want.most_probable,
				got.most_probable);
			mismatch_count++;
		end
		if (got.invalid !== want.invalid) begin
			$error("invalid: expected %0b, got %0b", want.invalid, got.invalid);
			mismatch_count++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
			mismatch_count++;
		end
	endtask

	// Request driver: holds a request while full, idles in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			push_gap <= 0;
		end else begin
			if (push && !full)
				process_species_request(item);
			if (push && full) begin
				// Keep the current request on the port.
			end else if (push_gap > 0) begin
				push <= 1'b0;
				push_gap <= push_gap - 1;
			end else if (!gaps_off && $urandom_range(0, 9) == 0) begin
				push <= 1'b0;
				push_gap <= $urandom_range(0, 7);
			end else if (requests_to_send.size() > 0) begin
				push <= 1'b1;
				item <= requests_to_send.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result monitor: pops with random stall bursts and checks each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
		end else begin
			if (pop && !empty)
				check_posterior(result);
			if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap <= pop_gap - 1;
			end else if (!gaps_off && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				pop_gap <= $urandom_range(0, 7);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic write_charged_only(input bit mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= mode;
		charged_mode = mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every request is sent and every posterior has arrived,
	// then let table writes still in the command queue drain.
	task automatic wait_drained();
		@(negedge clk);
		while (requests_to_send.size() != 0 || push || posteriors_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		repeat (count) requests_to_send.push_back(random_request());
	endtask

	// Stimulus: directed cases, then random phases in both modes.
	initial begin
		for (int i = 0; i < SPECIES_N; i++) begin
			density_mem[i] = bsp_pkg::FRAC_BITS'((1 << bsp_pkg::FRAC_BITS) / SPECIES_N);
			prior_mem[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_charged_only(1'b0);
		// Zero sum straight after reset, then a lone weight that saturates.
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd0, 16'd0));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd0, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd0, 16'd0));
		// Equal weights: the lower index wins.
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd13, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd0, 16'd0));
		// Combine at both extremes, smallest nonzero values.
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_DENSITY, 4'd13, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_COMBINE, 4'd13, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_COMBINE, 4'd0, 16'd0));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd5, 16'd1));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_DENSITY, 4'd5, 16'd1));
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd15, 16'hFFFF));
		// Out-of-range species are ignored.
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_DENSITY, 4'd14, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_COMBINE, 4'd15, 16'd0));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd15, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd9, 16'h8000));
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd0, 16'd0));
		// Clear the weights again for a second zero sum.
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd13, 16'd0));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd5, 16'd0));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd9, 16'd0));
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd0, 16'd0));
		wait_drained();

		// Charged mode: neutral density writes store zero, combine is not forced.
		write_charged_only(1'b1);
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_DENSITY, 4'd11, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_COMBINE, 4'd12, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd12, 16'hFFFF));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_PRIOR, 4'd1, 16'hAAAA));
		requests_to_send.push_back(make_req(bsp_pkg::OP_SET_DENSITY, 4'd1, 16'h5555));
		requests_to_send.push_back(make_req(bsp_pkg::OP_QUERY, 4'd0, 16'd0));
		queue_random(70);
		wait_drained();

		write_charged_only(1'b0);
		queue_random(72);
		wait_drained();

		write_charged_only(1'b1);
		queue_random(72);
		wait_drained();

		// Final phase runs back to back on both sides.
		write_charged_only(1'b0);
		gaps_off = 1'b1;
		queue_random(72);
		wait_drained();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
